/* rtl/core/bounded_sequence_store_unit_defines.svh */
// Assertion macros used by the store's back end.
// No dependencies; include by bare file name.
`ifndef BOUNDED_SEQUENCE_STORE_UNIT_DEFINES_SVH
`define BOUNDED_SEQUENCE_STORE_UNIT_DEFINES_SVH

// Assert that a implies b at the next edge.
`define BSS_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

// Assert that a implies b at the same edge.
`define BSS_ASSERT_NOW(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

`endif

/* rtl/core/bss_pkg.sv */
// Shared types and codes for the bounded sequence store.
// No dependencies.
`default_nettype none
package bss_pkg;
	localparam int unsigned ValW = 32;
	localparam int unsigned FuncW = 4;
	localparam int unsigned SizeW = 6;
	localparam int unsigned StoreDepth = 32;
	localparam int unsigned AddrW = $clog2(StoreDepth);

	localparam logic [FuncW-1:0] FN_ADD_BACK = 4'd0;
	localparam logic [FuncW-1:0] FN_ADD_FRONT = 4'd1;
	localparam logic [FuncW-1:0] FN_TAKE_BACK = 4'd2;
	localparam logic [FuncW-1:0] FN_TAKE_FRONT = 4'd3;
	localparam logic [FuncW-1:0] FN_REMOVE = 4'd4;
	localparam logic [FuncW-1:0] FN_UNIQUE = 4'd5;
	localparam logic [FuncW-1:0] FN_SORT = 4'd6;
	localparam logic [FuncW-1:0] FN_CLEAR = 4'd7;
	localparam logic [FuncW-1:0] FN_RESIZE = 4'd8;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef enum logic [3:0] {
		OP_NOP, OP_ADD_BACK, OP_ADD_FRONT, OP_TAKE_BACK, OP_TAKE_FRONT,
		OP_REMOVE, OP_UNIQUE, OP_SORT, OP_CLEAR, OP_RESIZE
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [ValW-1:0]  value;
		logic [SizeW-1:0] new_size;
	} cmd_t;

	typedef enum logic [3:0] {
		BK_IDLE, BK_SIMPLE, BK_CMP_RD, BK_CMP_WR, BK_SORT_RD, BK_SORT_KEY,
		BK_SORT_CMP, BK_SORT_WR, BK_FILL, BK_FRONT_RD, BK_BACK_RD, BK_REPORT
	} bk_state_t;
endpackage
`default_nettype wire

/* rtl/core/bss_front.sv */
// Front end: takes commands, decodes func into an operation, pushes the queue.
// Depends on bss_pkg.
`default_nettype none
module bss_front import bss_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [FuncW-1:0] func,
	input  wire logic [ValW-1:0]  item_value,
	input  wire logic [SizeW-1:0] new_size,
	input  wire logic             done,
	output logic                  busy,
	output logic                  q_push,
	output cmd_t                  q_cmd
);
	logic busy_q;
	op_t  op;

	always_comb begin
		case (func)
			FN_ADD_BACK:   op = OP_ADD_BACK;
			FN_ADD_FRONT:  op = OP_ADD_FRONT;
			FN_TAKE_BACK:  op = OP_TAKE_BACK;
			FN_TAKE_FRONT: op = OP_TAKE_FRONT;
			FN_REMOVE:     op = OP_REMOVE;
			FN_UNIQUE:     op = OP_UNIQUE;
			FN_SORT:       op = OP_SORT;
			FN_CLEAR:      op = OP_CLEAR;
			FN_RESIZE:     op = OP_RESIZE;
			default:       op = OP_NOP;
		endcase
	end

	// one command in flight: the store state is needed by the next one
	assign busy = busy_q;
	assign q_push = start & ~busy_q;
	assign q_cmd = '{op: op, value: item_value, new_size: new_size};

	// hold busy from the transfer until the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (q_push) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

/* rtl/core/bss_back.sv */
// Back end: executes commands on the ring memory and emits one result each.
// Depends on bss_pkg and bounded_sequence_store_unit_defines.svh.
`default_nettype none
module bss_back import bss_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_valid,
	input  wire cmd_t             cmd,
	output logic                  cmd_pop,
	output logic                  done,
	output logic [1:0]            status,
	output logic [ValW-1:0]       front_value,
	output logic [ValW-1:0]       back_value,
	output logic [SizeW-1:0]      entry_count,
	output logic                  is_empty
);
	`include "bounded_sequence_store_unit_defines.svh"

	logic [ValW-1:0] mem [StoreDepth];
	logic [ValW-1:0] rd_q;

	bk_state_t state_q, state_d;
	cmd_t      cmd_q;
	logic [AddrW-1:0] head_q;
	logic [SizeW-1:0] count_q;
	logic [SizeW-1:0] i_q, n_q, j_q;
	logic [ValW-1:0]  key_q, prev_q, front_q, back_q;
	logic [1:0]       st_q;
	logic             have_prev_q;
	logic             done_q;

	logic             we;
	logic [AddrW-1:0] waddr, raddr;
	logic [ValW-1:0]  wdata;
	logic             keep;
	logic             slt;
	logic             last_entry;
	logic             fill_last;
	logic             grow;

	function automatic logic [AddrW-1:0] slot(input logic [AddrW-1:0] h,
		input logic [SizeW-1:0] l);
		logic [SizeW:0] s;
		s = {{(SizeW+1-AddrW){1'b0}}, h} + {1'b0, l};
		if (s >= (SizeW+1)'(StoreDepth)) s = s - (SizeW+1)'(StoreDepth);
		return s[AddrW-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	assign slt = $signed(key_q) < $signed(rd_q);
	assign keep = (cmd_q.op == OP_REMOVE) ? (rd_q != cmd_q.value) :
		(!have_prev_q || (rd_q != prev_q));
	assign last_entry = (i_q + SizeW'(1) >= count_q);
	assign fill_last = (i_q + SizeW'(1) >= cmd_q.new_size);
	assign grow = (cmd_q.new_size <= SizeW'(StoreDepth)) && (cmd_q.new_size > count_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: if (cmd_valid) state_d = BK_SIMPLE;
			BK_SIMPLE: begin
				case (cmd_q.op)
					OP_REMOVE, OP_UNIQUE:
						state_d = (count_q == '0) ? BK_FRONT_RD : BK_CMP_RD;
					OP_SORT: state_d = (count_q < SizeW'(2)) ? BK_FRONT_RD : BK_SORT_RD;
					OP_RESIZE: state_d = grow ? BK_FILL : BK_FRONT_RD;
					default: state_d = BK_FRONT_RD;
				endcase
			end
			BK_CMP_RD: state_d = BK_CMP_WR;
			BK_CMP_WR: state_d = last_entry ? BK_FRONT_RD : BK_CMP_RD;
			BK_SORT_RD: state_d = BK_SORT_KEY;
			BK_SORT_KEY: state_d = BK_SORT_CMP;
			BK_SORT_CMP: if (j_q == '0 || !slt) state_d = BK_SORT_WR;
			BK_SORT_WR: state_d = last_entry ? BK_FRONT_RD : BK_SORT_RD;
			BK_FILL: state_d = fill_last ? BK_FRONT_RD : BK_FILL;
			BK_FRONT_RD: state_d = BK_BACK_RD;
			BK_BACK_RD: state_d = BK_REPORT;
			BK_REPORT: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		we = 1'b0;
		waddr = slot(head_q, '0);
		wdata = cmd_q.value;
		raddr = slot(head_q, '0);
		case (state_q)
			BK_SIMPLE: begin
				if (count_q < SizeW'(StoreDepth)) begin
					if (cmd_q.op == OP_ADD_BACK) begin
						we = 1'b1;
						waddr = slot(head_q, count_q);
					end else if (cmd_q.op == OP_ADD_FRONT) begin
						we = 1'b1;
						waddr = slot(head_q, SizeW'(StoreDepth - 1));
					end
				end
			end
			BK_CMP_RD: raddr = slot(head_q, i_q);
			BK_CMP_WR: begin
				we = keep;
				waddr = slot(head_q, n_q);
				wdata = rd_q;
			end
			BK_SORT_RD: raddr = slot(head_q, i_q);
			BK_SORT_KEY: raddr = slot(head_q, i_q - SizeW'(1));
			BK_SORT_CMP: begin
				// shift the bigger entry up, then read the next lower one
				if (j_q != '0 && slt) begin
					we = 1'b1;
					waddr = slot(head_q, j_q);
					wdata = rd_q;
				end
				raddr = slot(head_q, j_q - SizeW'(2));
			end
			BK_SORT_WR: begin
				we = 1'b1;
				waddr = slot(head_q, j_q);
				wdata = key_q;
			end
			BK_FILL: begin
				we = 1'b1;
				waddr = slot(head_q, i_q);
				wdata = '0;
			end
			BK_FRONT_RD: raddr = slot(head_q, '0);
			BK_BACK_RD: raddr = slot(head_q, count_q - SizeW'(1));
			default: ;
		endcase
	end

	assign cmd_pop = (state_q == BK_IDLE) && cmd_valid;

	always_ff @(posedge clk) begin
		if (cmd_pop) cmd_q <= cmd;
		case (state_q)
			BK_SIMPLE: begin
				i_q <= (cmd_q.op == OP_SORT) ? SizeW'(1) :
					(cmd_q.op == OP_RESIZE) ? count_q : '0;
				n_q <= '0;
				have_prev_q <= 1'b0;
			end
			BK_CMP_WR: begin
				if (keep) begin
					n_q <= n_q + SizeW'(1);
					prev_q <= rd_q;
					have_prev_q <= 1'b1;
				end
				i_q <= i_q + SizeW'(1);
			end
			BK_SORT_RD: j_q <= i_q;
			BK_SORT_KEY: key_q <= rd_q;
			BK_SORT_CMP: if (j_q != '0 && slt) j_q <= j_q - SizeW'(1);
			BK_SORT_WR: i_q <= i_q + SizeW'(1);
			BK_FILL: i_q <= i_q + SizeW'(1);
			BK_BACK_RD: front_q <= rd_q;
			BK_REPORT: back_q <= rd_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			head_q <= '0;
			count_q <= '0;
			st_q <= ST_OK;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= 1'b0;
			case (state_q)
				BK_SIMPLE: begin
					st_q <= ST_OK;
					case (cmd_q.op)
						OP_ADD_BACK, OP_ADD_FRONT: begin
							if (count_q >= SizeW'(StoreDepth)) begin
								st_q <= ST_FULL;
							end else begin
								count_q <= count_q + SizeW'(1);
								if (cmd_q.op == OP_ADD_FRONT)
									head_q <= slot(head_q, SizeW'(StoreDepth - 1));
							end
						end
						OP_TAKE_BACK, OP_TAKE_FRONT: begin
							if (count_q == '0) begin
								st_q <= ST_EMPTY;
							end else begin
								count_q <= count_q - SizeW'(1);
								if (cmd_q.op == OP_TAKE_FRONT)
									head_q <= slot(head_q, SizeW'(1));
							end
						end
						OP_CLEAR: count_q <= '0;
						OP_RESIZE: begin
							if (cmd_q.new_size > SizeW'(StoreDepth)) begin
								st_q <= ST_FULL;
							end else if (cmd_q.new_size <= count_q) begin
								count_q <= cmd_q.new_size;
							end
						end
						default: ;
					endcase
				end
				BK_CMP_WR: if (last_entry) count_q <= n_q + SizeW'(keep);
				BK_FILL: if (fill_last) count_q <= cmd_q.new_size;
				BK_REPORT: done_q <= 1'b1;
				default: ;
			endcase
		end
	end

	assign done = done_q;
	assign status = st_q;
	assign entry_count = count_q;
	assign is_empty = (count_q == '0);
	assign front_value = is_empty ? '0 : front_q;
	assign back_value = is_empty ? '0 : back_q;

	`BSS_ASSERT_NOW(a_count_max, clk, arst_n, 1'b1, count_q <= SizeW'(StoreDepth))
	`BSS_ASSERT_NEXT(a_pop_idle, clk, arst_n, cmd_pop, state_q == BK_SIMPLE)
	`BSS_ASSERT_NEXT(a_done_once, clk, arst_n, done, !done)
	`BSS_ASSERT_NOW(a_sort_j, clk, arst_n, state_q == BK_SORT_CMP, j_q <= i_q)
endmodule
`default_nettype wire

/* rtl/core/bounded_sequence_store_unit.sv */
// Top level of the bounded sequence store: front end, command queue, back end.
// Depends on bss_pkg, bss_front, bss_back.
`default_nettype none
// A command is taken when start is high and busy is low; one result follows
// with done high for a single cycle, which the receiver cannot stall. The
// command passes the one-entry queue, then the back end's idle, simple, front
// read, back read and report states before done; busy drops at the edge that
// samples done, so a new command waits for the last one's result. Remove and
// unique read and write back each entry held; sort on n >= 2 entries reads,
// keys, compares and writes each entry after the first, plus one compare per
// shift; a growing resize writes one appended zero at a time. The ring memory
// of 32 words, with a read and a write port, is walked one entry at a time.
// Hold busy high from the transfer until the result is shown.
module bounded_sequence_store_unit import bss_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [FuncW-1:0] func,
	input  wire logic [ValW-1:0]  item_value,
	input  wire logic [SizeW-1:0] new_size,
	output logic                  busy,
	output logic                  done,
	output logic [1:0]            status,
	output logic [ValW-1:0]       front_value,
	output logic [ValW-1:0]       back_value,
	output logic [SizeW-1:0]      entry_count,
	output logic                  is_empty
);
	logic q_push, q_pop, q_valid_q;
	cmd_t q_cmd, q_data_q;

	bss_front u_front (
		.clk, .arst_n, .start, .func, .item_value, .new_size,
		.done, .busy, .q_push, .q_cmd
	);

	// one-entry queue between front and back; advance on pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_valid_q <= 1'b0;
		end else if (q_push) begin
			q_valid_q <= 1'b1;
		end else if (q_pop) begin
			q_valid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (q_push) q_data_q <= q_cmd;
	end

	bss_back u_back (
		.clk, .arst_n, .cmd_valid(q_valid_q), .cmd(q_data_q), .cmd_pop(q_pop),
		.done, .status, .front_value, .back_value, .entry_count, .is_empty
	);
endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for bounded_sequence_store_unit.
// Depends on bss_pkg and the store RTL; predicts every result with a local deque model.
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import bss_pkg::*;

	localparam int unsigned CycleLimit = 5000000;
	localparam logic [FuncW-1:0] FnUnusedLo = 4'd9;
	localparam logic [FuncW-1:0] FnUnusedHi = 4'd15;

	typedef struct {
		logic [1:0]       status;
		logic [ValW-1:0]  front_value;
		logic [ValW-1:0]  back_value;
		logic [SizeW-1:0] entry_count;
		logic             is_empty;
	} outcome_t;

	int unsigned mismatch_count = 0;

	task automatic report(input string what, input logic [ValW-1:0] got,
		input logic [ValW-1:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// Scoreboard: holds a copy of the deque and the queue of pending outcomes.
	class deque_scoreboard;
		logic [ValW-1:0] entries[$];
		outcome_t pending[$];

		function void note_command(logic [FuncW-1:0] fn, logic [ValW-1:0] v,
			logic [SizeW-1:0] sz);
			logic [ValW-1:0] kept[$];
			logic [ValW-1:0] key;
			outcome_t o;
			int j;
			o.status = ST_OK;
			case (fn)
				FN_ADD_BACK: begin
					if (entries.size() >= StoreDepth) o.status = ST_FULL;
					else entries.insert(entries.size(), v);
				end
				FN_ADD_FRONT: begin
					if (entries.size() >= StoreDepth) o.status = ST_FULL;
					else entries.insert(0, v);
				end
				FN_TAKE_BACK: begin
					if (entries.size() == 0) o.status = ST_EMPTY;
					else entries.delete(entries.size() - 1);
				end
				FN_TAKE_FRONT: begin
					if (entries.size() == 0) o.status = ST_EMPTY;
					else entries.delete(0);
				end
				FN_REMOVE: begin
					foreach (entries[i])
						if (entries[i] != v) kept.insert(kept.size(), entries[i]);
					entries = kept;
				end
				FN_UNIQUE: begin
					foreach (entries[i])
						if (kept.size() == 0 || kept[$] != entries[i])
							kept.insert(kept.size(), entries[i]);
					entries = kept;
				end
				FN_SORT: begin
					// insertion sort, signed compare
					for (int i = 1; i < entries.size(); i++) begin
						key = entries[i];
						j = i;
						while (j > 0 && $signed(key) < $signed(entries[j-1])) begin
							entries[j] = entries[j-1];
							j--;
						end
						entries[j] = key;
					end
				end
				FN_CLEAR: entries.delete();
				FN_RESIZE: begin
					if (sz > StoreDepth) o.status = ST_FULL;
					else begin
						while (entries.size() < sz) entries.insert(entries.size(), '0);
						while (entries.size() > sz) entries.delete(entries.size() - 1);
					end
				end
				default: ;
			endcase
			o.entry_count = SizeW'(entries.size());
			o.is_empty = (entries.size() == 0);
			o.front_value = o.is_empty ? '0 : entries[0];
			o.back_value = o.is_empty ? '0 : entries[$];
			pending.insert(pending.size(), o);
		endfunction

		task check_result(logic [1:0] st, logic [ValW-1:0] fv,
			logic [ValW-1:0] bv, logic [SizeW-1:0] cnt, logic emp);
			outcome_t o;
			if (pending.size() == 0) begin
				report("unexpected result", '0, '0);
				return;
			end
			o = pending[0];
			pending.delete(0);
			if (st !== o.status) report("status", ValW'(st), ValW'(o.status));
			if (fv !== o.front_value) report("front_value", fv, o.front_value);
			if (bv !== o.back_value) report("back_value", bv, o.back_value);
			if (cnt !== o.entry_count)
				report("entry_count", ValW'(cnt), ValW'(o.entry_count));
			if (emp !== o.is_empty) report("is_empty", ValW'(emp), ValW'(o.is_empty));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [FuncW-1:0] func = '0;
	logic [ValW-1:0] item_value = '0;
	logic [SizeW-1:0] new_size = '0;
	logic busy, done, is_empty;
	logic [1:0] status;
	logic [ValW-1:0] front_value, back_value;
	logic [SizeW-1:0] entry_count;

	deque_scoreboard board = new();
	int unsigned sender_idle_pct = 0;
	int unsigned cycle_count = 0;
	int unsigned transfer_count = 0;
	int unsigned result_count = 0;
	int unsigned op_seen[16];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	bounded_sequence_store_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .func(func),
		.item_value(item_value), .new_size(new_size), .busy(busy), .done(done),
		.status(status), .front_value(front_value), .back_value(back_value),
		.entry_count(entry_count), .is_empty(is_empty)
	);

	// Sample at the rising edge: note a transfer, check a strobed result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				board.note_command(func, item_value, new_size);
				op_seen[func]++;
				transfer_count++;
			end
			if (done) begin
				board.check_result(status, front_value, back_value, entry_count, is_empty);
				result_count++;
			end
		end
	end

	// Watchdog: the limit is far beyond any legal run of the planned command
	// mix.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("TB_ERROR");
			$finish;
		end
	end

	// Drive one command and hold it until the transfer; idle first at random.
	// Busy only moves at rising edges, so its value at a falling edge tells
	// whether the next rising edge takes the command.
	task automatic send(input logic [FuncW-1:0] fn, input logic [ValW-1:0] v,
		input logic [SizeW-1:0] sz);
		logic taken;
		taken = 1'b0;
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		func <= fn;
		item_value <= v;
		new_size <= sz;
		start <= 1'b1;
		while (!taken) begin
			taken = !busy;
			@(negedge clk);
		end
	endtask

	// Values from a small pool so remove and unique find matches; else anything.
	function automatic logic [ValW-1:0] pick_value();
		case ($urandom_range(3))
			0: return $urandom_range(3);
			1: return 32'h8000_0000 + $urandom_range(1);
			2: return 32'h7FFF_FFFF - $urandom_range(1);
			default: return $urandom;
		endcase
	endfunction

	// Random command, weighted toward pushes so the store fills and drains.
	task automatic send_random();
		int unsigned r;
		logic [SizeW-1:0] sz;
		r = $urandom_range(99);
		sz = ($urandom_range(9) == 0) ? SizeW'($urandom) : SizeW'($urandom_range(StoreDepth));
		if (r < 28) send(FN_ADD_BACK, pick_value(), SizeW'($urandom));
		else if (r < 50) send(FN_ADD_FRONT, pick_value(), SizeW'($urandom));
		else if (r < 60) send(FN_TAKE_BACK, $urandom, SizeW'($urandom));
		else if (r < 70) send(FN_TAKE_FRONT, $urandom, SizeW'($urandom));
		else if (r < 78) send(FN_REMOVE, pick_value(), SizeW'($urandom));
		else if (r < 84) send(FN_UNIQUE, $urandom, SizeW'($urandom));
		else if (r < 88) send(FN_SORT, $urandom, SizeW'($urandom));
		else if (r < 90) send(FN_CLEAR, $urandom, SizeW'($urandom));
		else if (r < 96) send(FN_RESIZE, $urandom, sz);
		else send(FuncW'($urandom_range(FnUnusedHi, FnUnusedLo)), $urandom,
			SizeW'($urandom));
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty-store cases first, then fill, overflow and walk.
		send(FN_TAKE_BACK, '0, '0);
		send(FN_TAKE_FRONT, '0, '0);
		send(FN_REMOVE, '0, '0);
		send(FN_UNIQUE, '0, '0);
		send(FN_SORT, '0, '0);
		send(FN_CLEAR, '0, '0);
		send(FnUnusedLo, 32'hFFFF_FFFF, 6'h3F);
		send(FnUnusedHi, '0, '0);
		send(FN_ADD_BACK, 32'h7FFF_FFFF, '0);
		send(FN_ADD_FRONT, 32'h8000_0000, '0);
		send(FN_ADD_BACK, 32'hFFFF_FFFF, '0);
		send(FN_ADD_BACK, 32'hFFFF_FFFF, '0);
		send(FN_UNIQUE, '0, '0);
		send(FN_SORT, '0, '0);
		send(FN_REMOVE, 32'h8000_0000, '0);
		send(FN_RESIZE, '0, 6'd33);
		send(FN_RESIZE, '0, 6'h3F);
		send(FN_RESIZE, '0, SizeW'(StoreDepth));
		send(FN_ADD_BACK, 32'h1234_5678, '0);
		send(FN_ADD_FRONT, 32'h1234_5678, '0);
		send(FN_SORT, '0, '0);
		send(FN_TAKE_FRONT, '0, '0);
		send(FN_TAKE_BACK, '0, '0);
		send(FN_RESIZE, '0, '0);
		send(FN_RESIZE, '0, 6'd1);

		// Random phases: sender idles often, then more often, then never.
		sender_idle_pct = 22;
		repeat (650) send_random();
		sender_idle_pct = 47;
		repeat (650) send_random();
		sender_idle_pct = 0;
		repeat (650) send_random();
		start <= 1'b0;

		fork
			while (board.pending.size() != 0) @(posedge clk);
			begin
				repeat (5000) @(posedge clk);
			end
		join_any
		disable fork;
		repeat (20) @(posedge clk);

		$display("covered %0d transfers, %0d results; pushes %0d/%0d, pops %0d/%0d",
			transfer_count, result_count, op_seen[FN_ADD_BACK], op_seen[FN_ADD_FRONT],
			op_seen[FN_TAKE_BACK], op_seen[FN_TAKE_FRONT]);
		$display("remove %0d, unique %0d, sort %0d, clear %0d, resize %0d",
			op_seen[FN_REMOVE], op_seen[FN_UNIQUE], op_seen[FN_SORT],
			op_seen[FN_CLEAR], op_seen[FN_RESIZE]);
		if (mismatch_count == 0 && board.pending.size() == 0) begin
			$display("TB_OK");
		end else begin
			if (board.pending.size() != 0)
				$display("%0d results never arrived", board.pending.size());
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+rtl/core
rtl/core/bss_pkg.sv
rtl/core/bss_front.sv
rtl/core/bss_back.sv
rtl/core/bounded_sequence_store_unit.sv
tb/tb.sv
